[design/lslp_pkg.sv]
// ----------------------------------------------------------------------------
// lslp_pkg: shared types and constants of the link status LED pattern unit
// Link state codes, LED colours, register indexes, state and config records.
// ----------------------------------------------------------------------------
package lslp_pkg;

    // Width of the internal millisecond time base
    localparam int TIME_WIDTH = 32;
    // Width of the timestamp field on the request port
    localparam int TS_WIDTH   = 32;
    localparam int DUR_WIDTH  = 16;
    localparam int CFG_IDX_W  = 3;

    // Link state codes
    localparam logic [2:0] LINK_BOOT       = 3'd0;
    localparam logic [2:0] LINK_DISCONN    = 3'd1;
    localparam logic [2:0] LINK_PREOP      = 3'd2;
    localparam logic [2:0] LINK_OPER       = 3'd3;
    localparam logic [2:0] LINK_HB_LOST    = 3'd4;
    localparam logic [2:0] LINK_ERROR      = 3'd5;

    // LED colours: bit0 red, bit1 green, bit2 blue
    localparam logic [2:0] COLOUR_OFF   = 3'h0;
    localparam logic [2:0] COLOUR_WHITE = 3'h7;
    localparam logic [2:0] COLOUR_RED   = 3'h1;
    localparam logic [2:0] COLOUR_GREEN = 3'h2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_REST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_BLINK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_BLINK = 3'd4;

    // Register reset values
    localparam logic [DUR_WIDTH-1:0] RST_FLASH_ON      = 16'd200;
    localparam logic [DUR_WIDTH-1:0] RST_FLASH_GAP     = 16'd200;
    localparam logic [DUR_WIDTH-1:0] RST_FLASH_REST    = 16'd1000;
    localparam logic [DUR_WIDTH-1:0] RST_ERROR_BLINK   = 16'd200;
    localparam logic [DUR_WIDTH-1:0] RST_UNKNOWN_BLINK = 16'd100;

    typedef struct packed {
        logic [DUR_WIDTH-1:0] flash_on;
        logic [DUR_WIDTH-1:0] flash_gap;
        logic [DUR_WIDTH-1:0] flash_rest;
        logic [DUR_WIDTH-1:0] error_blink;
        logic [DUR_WIDTH-1:0] unknown_blink;
    } t_cfg;

    typedef struct packed {
        logic [2:0]            link;
        logic [TIME_WIDTH-1:0] last_toggle;
        logic                  blink_lit;
        logic [1:0]            phase;
        logic [2:0]            drive;
    } t_state;

    // Colour shown for a link state
    function automatic logic [2:0] colour_of(input logic [2:0] st);
        logic [2:0] c;
        case (st)
            LINK_BOOT:               c = COLOUR_WHITE;
            LINK_PREOP, LINK_OPER:   c = COLOUR_GREEN;
            default:                 c = COLOUR_RED;
        endcase
        return c;
    endfunction

    // Duration of the current flash phase
    function automatic logic [DUR_WIDTH-1:0] flash_duration(
        input logic [2:0] st, input logic [1:0] ph, input t_cfg cfg);
        logic [DUR_WIDTH-1:0] d;
        if (st == LINK_PREOP) begin
            d = ph[0] ? cfg.flash_rest : cfg.flash_on;
        end else begin
            case (ph)
                2'd1:    d = cfg.flash_gap;
                2'd3:    d = cfg.flash_rest;
                default: d = cfg.flash_on;
            endcase
        end
        return d;
    endfunction

endpackage

[design/lslp_step.sv]
// ----------------------------------------------------------------------------
// lslp_step: next pattern state for one request
// Applies a set (new link state) or an update (timestamp) to the state.
// ----------------------------------------------------------------------------
module lslp_step (
    input  lslp_pkg::t_state                  i_state,
    input  lslp_pkg::t_cfg                    i_cfg,
    input  logic                              i_set,
    input  logic [lslp_pkg::TIME_WIDTH-1:0]   i_now,
    input  logic [2:0]                        i_link,
    output lslp_pkg::t_state                  o_state
);

    logic [lslp_pkg::TIME_WIDTH-1:0] elapsed;
    logic [lslp_pkg::DUR_WIDTH-1:0]  dur;
    logic                            is_flash;
    logic                            is_blink;
    logic [1:0]                      ph_next;

    // Wrapped time since the last toggle
    assign elapsed  = i_now - i_state.last_toggle;
    assign is_flash = (i_state.link == lslp_pkg::LINK_PREOP) ||
                      (i_state.link == lslp_pkg::LINK_HB_LOST);
    assign is_blink = (i_state.link >= lslp_pkg::LINK_ERROR);

    // Pick the duration of the running phase or blink half period
    always_comb begin
        if (is_flash) begin
            dur = lslp_pkg::flash_duration(i_state.link, i_state.phase, i_cfg);
        end else if (i_state.link == lslp_pkg::LINK_ERROR) begin
            dur = i_cfg.error_blink;
        end else begin
            dur = i_cfg.unknown_blink;
        end
    end

    // Single flash has two phases, double flash four
    always_comb begin
        ph_next = i_state.phase + 2'd1;
        if (i_state.link == lslp_pkg::LINK_PREOP) begin
            ph_next[1] = 1'b0;
        end
    end

    // Work out the next state
    always_comb begin
        o_state = i_state;
        if (i_set) begin
            if (i_link != i_state.link) begin
                o_state.link        = i_link;
                o_state.phase       = 2'd0;
                o_state.last_toggle = '0;
                o_state.blink_lit   = 1'b1;
                o_state.drive       = lslp_pkg::colour_of(i_link);
            end
        end else if (elapsed >= lslp_pkg::TIME_WIDTH'(dur)) begin
            if (is_flash) begin
                o_state.last_toggle = i_now;
                o_state.phase       = ph_next;
                o_state.drive       = ph_next[0] ? lslp_pkg::COLOUR_OFF
                                                 : lslp_pkg::colour_of(i_state.link);
            end else if (is_blink) begin
                o_state.last_toggle = i_now;
                o_state.blink_lit   = ~i_state.blink_lit;
                o_state.drive       = i_state.blink_lit ? lslp_pkg::COLOUR_OFF
                                                        : lslp_pkg::colour_of(i_state.link);
            end
        end
    end

endmodule

[design/link_status_led_pattern_unit.sv]
// ----------------------------------------------------------------------------
// link_status_led_pattern_unit: RGB status LED pattern from a link state
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle; the output register sets the pace and
// a new request is taken whenever that register is empty or being drained.
// Reset (synchronous, active low): boot-up state, white, phase 0, register
// defaults loaded, output empty.
// ----------------------------------------------------------------------------
module link_status_led_pattern_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [39:0]                    i_s_axis_tdata,  // [31:0] tick_ms, [34:32] link_state
    input  logic                           i_s_axis_tuser,  // [0] operation
    // Result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,  // [2:0] rgb_mask, [5:3] shown_state
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lslp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    lslp_pkg::t_state                r_state;
    lslp_pkg::t_state                n_state;
    lslp_pkg::t_cfg                  r_cfg;
    logic                            r_out_valid;
    logic [7:0]                      r_out_data;
    logic                            in_accept;
    logic [lslp_pkg::TIME_WIDTH-1:0] now;

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign now             = lslp_pkg::TIME_WIDTH'(i_s_axis_tdata[lslp_pkg::TS_WIDTH-1:0]);

    lslp_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_set   (i_s_axis_tuser),
        .i_now   (now),
        .i_link  (i_s_axis_tdata[34:32]),
        .o_state (n_state)
    );

    // Hold the pattern state, advance it on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.link        <= lslp_pkg::LINK_BOOT;
            r_state.last_toggle <= '0;
            r_state.blink_lit   <= 1'b1;
            r_state.phase       <= 2'd0;
            r_state.drive       <= lslp_pkg::COLOUR_WHITE;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Write configuration registers; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_on      <= lslp_pkg::RST_FLASH_ON;
            r_cfg.flash_gap     <= lslp_pkg::RST_FLASH_GAP;
            r_cfg.flash_rest    <= lslp_pkg::RST_FLASH_REST;
            r_cfg.error_blink   <= lslp_pkg::RST_ERROR_BLINK;
            r_cfg.unknown_blink <= lslp_pkg::RST_UNKNOWN_BLINK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lslp_pkg::REG_FLASH_ON:      r_cfg.flash_on      <= i_cfg_data;
                lslp_pkg::REG_FLASH_GAP:     r_cfg.flash_gap     <= i_cfg_data;
                lslp_pkg::REG_FLASH_REST:    r_cfg.flash_rest    <= i_cfg_data;
                lslp_pkg::REG_ERROR_BLINK:   r_cfg.error_blink   <= i_cfg_data;
                lslp_pkg::REG_UNKNOWN_BLINK: r_cfg.unknown_blink <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result of each accepted request
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {2'b00, n_state.link, n_state.drive};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
